FILE: src/scpr_pkg.sv
// Package for the second-chance page replacer: field widths, defaults,
// engine state codes and the result word layout.
// No dependencies.
package scpr_pkg;

    // Fixed port field widths
    localparam int PAGE_NUMBER_W = 20;
    localparam int FRAME_INDEX_W = 2;
    localparam int FAULT_W       = 32;

    // Default sizing
    localparam int FRAMES_DEFAULT    = 4;
    localparam int PAGE_BITS_DEFAULT = 20;

    // Depth of the input and result queues
    localparam int QUEUE_DEPTH = 2;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_LOOK,
        ENG_COMMIT
    } eng_state_t;

    // One result word
    typedef struct packed {
        logic                     hit;
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic                     evicted_valid;
        logic [PAGE_NUMBER_W-1:0] evicted_page;
        logic [FAULT_W-1:0]       fault_total;
    } scpr_result_t;

endpackage

FILE: src/scpr_fifo.sv
// Small register queue used on both sides of the replacement engine.
// Depends on nothing but its parameters.
module scpr_fifo #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");
`endif

endmodule

FILE: src/scpr_engine.sv
// Replacement engine: frame table, clock hand and fault counter; looks up
// one page, picks a victim and commits the update. Uses scpr_pkg.
module scpr_engine
    import scpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEFAULT,
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [PAGE_NUMBER_W-1:0] in_page,
    output logic                     in_pop,
    input  logic                     out_full,
    output logic                     out_push,
    output scpr_result_t             out_data
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    eng_state_t             state_reg, state_next;
    logic [PAGE_BITS-1:0]   page_reg;
    logic [PAGE_BITS-1:0]   tag_reg [FRAMES];
    logic [FRAMES-1:0]      valid_reg;
    logic [FRAMES-1:0]      ref_reg;
    logic [IDX_W-1:0]       hand_reg;
    logic [FAULT_W-1:0]     fault_counter_reg;

    // Lookup results held for the commit cycle
    logic                   hit_reg;
    logic [IDX_W-1:0]       sel_idx_reg;
    logic [FRAMES-1:0]      ref_new_reg;
    logic                   old_valid_reg;
    logic [PAGE_BITS-1:0]   old_tag_reg;
    logic [IDX_W-1:0]       hand_new_reg;

    logic [31:0]            page_ext;
    logic                   hit_c;
    logic [IDX_W-1:0]       hit_idx_c;
    logic [2*FRAMES-1:0]    ref_dbl;
    logic [FRAMES-1:0]      ref_rot;
    logic                   found_c;
    logic [IDX_W:0]         offset_c;
    logic [IDX_W:0]         offset_eff;
    logic [IDX_W:0]         victim_sum;
    logic [IDX_W-1:0]       victim_c;
    logic [IDX_W-1:0]       hand_adv_c;
    logic [FRAMES-1:0]      ref_new_c;
    logic [IDX_W:0]         sweep_dist;
    logic                   commit;
    logic [31:0]            idx_ext;
    logic [31:0]            tag_ext;

    assign page_ext = 32'(in_page);

    // Parallel tag compare, lowest matching frame wins
    always_comb
    begin
        hit_c     = 1'b0;
        hit_idx_c = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == page_reg))
            begin
                hit_c     = 1'b1;
                hit_idx_c = IDX_W'(i);
            end
        end
    end

    // Search from the hand for the first clear reference bit
    assign ref_dbl = {ref_reg, ref_reg};
    assign ref_rot = FRAMES'(ref_dbl >> hand_reg);

    always_comb
    begin
        found_c  = 1'b0;
        offset_c = '0;
        for (int k = FRAMES - 1; k >= 0; k--)
        begin
            if (!ref_rot[k])
            begin
                found_c  = 1'b1;
                offset_c = (IDX_W + 1)'(k);
            end
        end
    end

    assign offset_eff = found_c ? offset_c : (IDX_W + 1)'(FRAMES);
    assign victim_sum = {1'b0, hand_reg} + (found_c ? offset_c : '0);
    assign victim_c   = (victim_sum >= (IDX_W + 1)'(FRAMES))
                        ? IDX_W'(victim_sum - (IDX_W + 1)'(FRAMES))
                        : IDX_W'(victim_sum);
    assign hand_adv_c = (victim_c == IDX_W'(FRAMES - 1)) ? '0 : victim_c + 1'b1;

    // New reference bits: clear what the sweep passes, set the frame used
    always_comb
    begin
        ref_new_c  = ref_reg;
        sweep_dist = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (hit_c)
            begin
                if (hit_idx_c == IDX_W'(i))
                begin
                    ref_new_c[i] = 1'b1;
                end
            end
            else
            begin
                if (IDX_W'(i) >= hand_reg)
                begin
                    sweep_dist = (IDX_W + 1)'(i) - {1'b0, hand_reg};
                end
                else
                begin
                    sweep_dist = (IDX_W + 1)'(i + FRAMES) - {1'b0, hand_reg};
                end
                if (victim_c == IDX_W'(i))
                begin
                    ref_new_c[i] = 1'b1;
                end
                else if (sweep_dist < offset_eff)
                begin
                    ref_new_c[i] = 1'b0;
                end
            end
        end
    end

    // Sequencer: take a page, look it up, commit when the result queue has room
    assign commit = (state_reg == ENG_COMMIT) && !out_full;

    always_comb
    begin
        state_next = state_reg;
        in_pop     = 1'b0;
        out_push   = 1'b0;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (in_valid)
                begin
                    in_pop     = 1'b1;
                    state_next = ENG_LOOK;
                end
            end
            ENG_LOOK:
            begin
                state_next = ENG_COMMIT;
            end
            ENG_COMMIT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    if (in_valid)
                    begin
                        in_pop     = 1'b1;
                        state_next = ENG_LOOK;
                    end
                    else
                    begin
                        state_next = ENG_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // Build the result word
    assign idx_ext = 32'(sel_idx_reg);
    assign tag_ext = 32'(old_tag_reg);

    always_comb
    begin
        out_data.hit           = hit_reg;
        out_data.frame_index   = idx_ext[FRAME_INDEX_W-1:0];
        out_data.evicted_valid = !hit_reg && old_valid_reg;
        out_data.evicted_page  = (!hit_reg && old_valid_reg)
                                 ? tag_ext[PAGE_NUMBER_W-1:0] : '0;
        out_data.fault_total   = hit_reg ? fault_counter_reg
                                         : fault_counter_reg + 1'b1;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ENG_IDLE;
            valid_reg         <= '0;
            ref_reg           <= '0;
            hand_reg          <= '0;
            fault_counter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                ref_reg <= ref_new_reg;
                if (!hit_reg)
                begin
                    valid_reg[sel_idx_reg] <= 1'b1;
                    hand_reg               <= hand_new_reg;
                    fault_counter_reg      <= fault_counter_reg + 1'b1;
                end
            end
        end
    end

    // Payload: page, lookup results and frame tags
    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            page_reg <= page_ext[PAGE_BITS-1:0];
        end
        if (state_reg == ENG_LOOK)
        begin
            hit_reg       <= hit_c;
            sel_idx_reg   <= hit_c ? hit_idx_c : victim_c;
            ref_new_reg   <= ref_new_c;
            old_valid_reg <= valid_reg[victim_c];
            old_tag_reg   <= tag_reg[victim_c];
            hand_new_reg  <= hand_adv_c;
        end
        if (commit && !hit_reg)
        begin
            tag_reg[sel_idx_reg] <= page_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_ref_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ref_reg & ~valid_reg) == '0)
        else $error("reference bit set on an empty frame");

    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !hit_reg) |=> fault_counter_reg == $past(fault_counter_reg) + 1'b1)
        else $error("fault counter did not advance on a miss");

    a_victim_filled: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> valid_reg[$past(sel_idx_reg)] && ref_reg[$past(sel_idx_reg)])
        else $error("frame used is not valid and referenced after commit");
`endif

endmodule

FILE: src/second_chance_page_replacer_core.sv
// Second-chance page replacer, top level: input queue, replacement engine,
// result queue. A word passes the input queue, the engine's lookup and commit
// states and the result queue. One word at a time: lookup (tag compare and
// victim search from the hand), then commit, which waits for result room.
// Reset clears all frames, reference bits, the clock hand and the fault count;
// no clearing pass, the block accepts words right after reset.
module second_chance_page_replacer_core
    import scpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEFAULT,
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [PAGE_NUMBER_W-1:0] access_page,
    output logic                     empty,
    input  logic                     pop,
    output logic                     hit,
    output logic [FRAME_INDEX_W-1:0] frame_index,
    output logic                     evicted_valid,
    output logic [PAGE_NUMBER_W-1:0] evicted_page,
    output logic [FAULT_W-1:0]       fault_total
);

    logic                     in_empty;
    logic [PAGE_NUMBER_W-1:0] in_page;
    logic                     in_pop;
    logic                     out_full;
    logic                     out_push;
    scpr_result_t             out_data;
    scpr_result_t             res;

    // Front: hold incoming page numbers
    scpr_fifo #(
        .WIDTH (PAGE_NUMBER_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (access_page),
        .full    (full),
        .pop     (in_pop),
        .rd_data (in_page),
        .empty   (in_empty)
    );

    // Back: lookup and replacement
    scpr_engine #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!in_empty),
        .in_page  (in_page),
        .in_pop   (in_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_data)
    );

    // Result queue toward the consumer
    scpr_fifo #(
        .WIDTH ($bits(scpr_result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (out_data),
        .full    (out_full),
        .pop     (pop),
        .rd_data (res),
        .empty   (empty)
    );

    assign hit           = res.hit;
    assign frame_index   = res.frame_index;
    assign evicted_valid = res.evicted_valid;
    assign evicted_page  = res.evicted_page;
    assign fault_total   = res.fault_total;

endmodule
